FILE: hw/rtl/udiv64_pkg.sv
// ----------------------------------------------------------------------------
// udiv64_pkg
// Shared widths and payload types for the pipelined unsigned divider.
// ----------------------------------------------------------------------------
package udiv64_pkg;

  localparam int unsigned DATA_WIDTH = 64;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] dividend;
    logic [DATA_WIDTH-1:0] divisor;
  } udiv64_in_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] quotient;
    logic [DATA_WIDTH-1:0] remainder;
  } udiv64_out_t;

  // In-flight state of one division.
  // num holds the dividend bits still to be consumed, MSB first.
  typedef struct packed {
    logic [DATA_WIDTH-1:0] rem;
    logic [DATA_WIDTH-1:0] num;
    logic [DATA_WIDTH-1:0] den;
    logic [DATA_WIDTH-1:0] quo;
  } udiv64_work_t;

endpackage

FILE: hw/rtl/udiv64_stage.sv
// ----------------------------------------------------------------------------
// udiv64_stage
// One restoring shift-subtract step with its pipeline register.
// ----------------------------------------------------------------------------
module udiv64_stage (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  udiv64_pkg::udiv64_work_t in_work,
  output logic                     out_valid,
  input  logic                     out_ready,
  output udiv64_pkg::udiv64_work_t out_work
);

  logic                            valid_r;
  udiv64_pkg::udiv64_work_t        work_r;
  udiv64_pkg::udiv64_work_t        work_nxt;
  logic [udiv64_pkg::DATA_WIDTH:0]   trial;
  logic [udiv64_pkg::DATA_WIDTH+1:0] diff;
  logic                            qbit;

  assign in_ready = !valid_r || out_ready;

  // trial = carry bit, shifted remainder and next dividend bit
  assign trial = {in_work.rem, in_work.num[udiv64_pkg::DATA_WIDTH-1]};
  assign diff  = {1'b0, trial} - {2'b00, in_work.den};
  assign qbit  = !diff[udiv64_pkg::DATA_WIDTH+1];

  always_comb begin
    work_nxt     = in_work;
    work_nxt.rem = qbit ? diff[udiv64_pkg::DATA_WIDTH-1:0]
                        : trial[udiv64_pkg::DATA_WIDTH-1:0];
    work_nxt.num = {in_work.num[udiv64_pkg::DATA_WIDTH-2:0], 1'b0};
    work_nxt.quo = {in_work.quo[udiv64_pkg::DATA_WIDTH-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      work_r <= work_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_work  = work_r;

endmodule

FILE: hw/rtl/unsigned_divider_64.sv
// ----------------------------------------------------------------------------
// unsigned_divider_64
// Pipelined unsigned restoring divider, quotient and remainder.
//
// Input channel in_valid/in_ready/in_data carries dividend and divisor;
// output channel out_valid/out_ready/out_data returns quotient and
// remainder, one result per transaction, in order.
// One quotient bit is resolved per stage: DATA_WIDTH stages, each holding
// one DATA_WIDTH+1 bit subtract and its register.
// Each input transaction passes through every stage register to reach out_valid.
// Throughput: one transaction per cycle while out_ready stays high.
// The last stage register drives the output. A stalled receiver holds
// the result there; upstream stages keep moving into empty slots, so
// input is accepted until the pipeline is full.
// Divide by zero returns all ones quotient and the dividend as remainder.
// Reset (rst_n low, synchronous) empties every stage; data in flight is
// dropped.
// ----------------------------------------------------------------------------
module unsigned_divider_64 (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  udiv64_pkg::udiv64_in_t  in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output udiv64_pkg::udiv64_out_t out_data
);

  localparam int unsigned W = udiv64_pkg::DATA_WIDTH;

  logic                     stg_valid [W+1];
  logic                     stg_ready [W+1];
  udiv64_pkg::udiv64_work_t stg_work  [W+1];

  always_comb begin
    stg_work[0]     = '0;
    stg_work[0].num = in_data.dividend;
    stg_work[0].den = in_data.divisor;
  end

  assign stg_valid[0] = in_valid;
  assign in_ready     = stg_ready[0];

  for (genvar i = 0; i < W; i++) begin : g_stage
    udiv64_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (stg_valid[i]),
      .in_ready  (stg_ready[i]),
      .in_work   (stg_work[i]),
      .out_valid (stg_valid[i+1]),
      .out_ready (stg_ready[i+1]),
      .out_work  (stg_work[i+1])
    );
  end

  assign stg_ready[W]       = out_ready;
  assign out_valid          = stg_valid[W];
  assign out_data.quotient  = stg_work[W].quo;
  assign out_data.remainder = stg_work[W].rem;

  // remainder is always below a nonzero divisor
  a_rem_lt_den: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (stg_work[W].den != '0)) |-> (stg_work[W].rem < stg_work[W].den))
    else $error("remainder not below divisor");

  // divide by zero gives all ones quotient
  a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (stg_work[W].den == '0)) |-> (stg_work[W].quo == '1))
    else $error("divide by zero quotient not all ones");

  // every dividend bit is consumed by the last stage
  a_num_consumed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (stg_work[W].num == '0))
    else $error("dividend bits left unconsumed");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

FILE: test/unsigned_divider_64_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unsigned_divider_64_tb
// Self-checking bench for the pipelined 64-bit unsigned divider.
//
// Directed corner operands come first, then random operand pairs of random
// bit lengths under three traffic patterns: busy input with a slow
// receiver, sparse input with a mostly ready receiver, and full rate both ways.
// Each accepted transaction is predicted by a bit-serial restoring division,
// and results are checked in order, quotient and remainder separately.
// ----------------------------------------------------------------------------
module unsigned_divider_64_tb;

  localparam int unsigned DATA_WIDTH  = udiv64_pkg::DATA_WIDTH;
  localparam int unsigned PHASE_ITEMS = 330;
  localparam int unsigned MAX_CYCLES  = 600000;
  localparam int unsigned MAX_REPORTS = 10;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  udiv64_pkg::udiv64_in_t  in_data;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  udiv64_pkg::udiv64_out_t out_data;

  udiv64_pkg::udiv64_out_t expected_results[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  unsigned_divider_64 DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Restoring division with a partial remainder one bit wider than the data.
  function automatic udiv64_pkg::udiv64_out_t predict_division(
      udiv64_pkg::udiv64_in_t operands);
    logic [DATA_WIDTH:0]     partial;
    udiv64_pkg::udiv64_out_t res;
    partial = '0;
    res     = '0;
    for (int pos = DATA_WIDTH - 1; pos >= 0; pos--) begin
      partial = {partial[DATA_WIDTH-1:0], operands.dividend[pos]};
      if (partial >= {1'b0, operands.divisor}) begin
        partial           = partial - {1'b0, operands.divisor};
        res.quotient[pos] = 1'b1;
      end
    end
    res.remainder = partial[DATA_WIDTH-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    udiv64_pkg::udiv64_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected transaction: quotient %h remainder %h",
                   out_data.quotient, out_data.remainder);
      end else begin
        want = expected_results.pop_front();
        if (out_data.quotient !== want.quotient ||
            out_data.remainder !== want.remainder) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: quotient exp %h act %h, remainder exp %h act %h",
                     want.quotient, out_data.quotient,
                     want.remainder, out_data.remainder);
        end
      end
    end
  end

  // Called and returns at a rising edge; in_valid stays high between back-to-back sends.
  task automatic send_division(input logic [DATA_WIDTH-1:0] dividend,
                               input logic [DATA_WIDTH-1:0] divisor);
    udiv64_pkg::udiv64_in_t item;
    item.dividend = dividend;
    item.divisor  = divisor;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(predict_division(item));
  endtask

  task automatic drain_divisions();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [DATA_WIDTH-1:0] random_operand();
    logic [DATA_WIDTH-1:0] value;
    int unsigned           len;
    value = {$urandom, $urandom};
    len   = $urandom_range(DATA_WIDTH);
    return (len == 0) ? '0 : value >> (DATA_WIDTH - len);
  endfunction

  task automatic test_corner_cases();
    logic [DATA_WIDTH-1:0] all_ones;
    logic [DATA_WIDTH-1:0] top_bit;
    all_ones = '1;
    top_bit  = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // divide by zero
    send_division('0, '0);
    send_division(all_ones, '0);
    send_division(64'h0123_4567_89ab_cdef, '0);
    send_division('0, 64'd1);
    send_division(all_ones, 64'd1);
    send_division(all_ones, all_ones);
    send_division('0, all_ones);
    send_division(all_ones - 64'd1, all_ones);
    send_division(all_ones, all_ones - 64'd1);
    // divisors with the top bit set need the extra partial remainder bit
    send_division(top_bit, top_bit);
    send_division(top_bit, top_bit + 64'd1);
    send_division(all_ones, top_bit);
    send_division(all_ones, top_bit + 64'd1);
    send_division(top_bit - 64'd1, top_bit);
    send_division(top_bit, 64'd3);
    send_division(all_ones, 64'd2);
    send_division(64'd5, 64'd7);
    send_division(64'd7, 64'd7);
    send_division(64'd123456789, 64'd1000);
    send_division(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    send_division(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    drain_divisions();
  endtask

  task automatic test_random_operands(input int unsigned send_pct,
                                      input int unsigned recv_pct);
    logic [DATA_WIDTH-1:0] dividend;
    logic [DATA_WIDTH-1:0] divisor;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
      case ($urandom_range(3))
        0: begin
          dividend = {$urandom, $urandom};
          divisor  = {$urandom, $urandom};
        end
        1: begin
          dividend = random_operand();
          divisor  = random_operand();
        end
        2: begin
          divisor  = random_operand();
          dividend = divisor + DATA_WIDTH'($urandom_range(3)) - 64'd1;
        end
        default: begin
          dividend = {$urandom, $urandom};
          divisor  = random_operand() >> $urandom_range(48);
        end
      endcase
      send_division(dividend, divisor);
    end
    drain_divisions();
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_corner_cases();
    test_random_operands(27, 71);
    test_random_operands(71, 27);
    test_random_operands(0, 0);

    in_valid <= 1'b0;
    repeat (DATA_WIDTH + 16) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
